>>> rtl/dtqs_pkg.sv
// Package for the delayed task queue scheduler: payload structs, request and
// status codes, and store sizes. No dependencies.
package dtqs_pkg;
    localparam int QUEUE_SLOTS = 16;
    localparam int TIMER_SLOTS = 16;
    localparam int DELAY_BITS  = 32;
    localparam int QIDX_W = $clog2(QUEUE_SLOTS);
    localparam int TIDX_W = $clog2(TIMER_SLOTS);
    localparam int TCNT_W = $clog2(TIMER_SLOTS + 1);

    localparam logic [3:0] REQ_TICK      = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK = 4'd1;
    localparam logic [3:0] REQ_PUSH_FRNT = 4'd2;
    localparam logic [3:0] REQ_START     = 4'd3;
    localparam logic [3:0] REQ_UPDATE    = 4'd4;
    localparam logic [3:0] REQ_DELETE    = 4'd5;
    localparam logic [3:0] REQ_DISPATCH  = 4'd6;
    localparam logic [3:0] REQ_CLR_TASKS = 4'd7;
    localparam logic [3:0] REQ_CLR_TMRS  = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_QOVF     = 3'd2;
    localparam logic [2:0] ST_TFULL    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] count;
        logic [31:0] ref_arg;
    } t_desc;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] task_handle;
        logic [15:0] arg_count;
        logic [31:0] arg_ref;
        logic [31:0] delay_ticks;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        task_valid;
        logic [15:0] out_task_handle;
        logic [15:0] out_arg_count;
        logic [31:0] out_arg_ref;
        logic [4:0]  fired_count;
        logic [4:0]  free_task_slots;
        logic [4:0]  free_timer_slots;
        logic [31:0] tick_count;
    } t_rsp;
endpackage

>>> rtl/dtqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dtqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/delayed_task_queue_scheduler.sv
// Delayed task queue scheduler top level; uses dtqs_pkg and dtqs_ram.
// Push, start and clear requests finish after the decode state; dispatch adds a queue read;
// tick, update and delete walk the timer table, with read-wait-act steps per timer passed
// and a further read of the last entry and move into the hole per timer removed.
// Busy holds through the result beat, so a new request is taken only after it.
// Reset (synchronous, active low) empties queue and table and clears the tick counter.
module delayed_task_queue_scheduler (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dtqs_pkg::t_req         i_req,
    output logic                   o_done,
    output dtqs_pkg::t_rsp         o_rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import dtqs_pkg::*;

    // Sequencer states. The timer walk is a loop of read-wait-act steps over
    // the table; a removal reads the last entry and writes it into the hole.
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_QRD, S_QOUT, S_TRD, S_TWAIT, S_TACT,
        S_LRD, S_LWAIT, S_LMOVE, S_DONE
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [QIDX_W-1:0]   r_head, r_tail;
    logic [TCNT_W-1:0]   r_used;
    logic [31:0]         r_ticks;
    logic [31:0]         r_retry;
    logic [TCNT_W-1:0]   r_idx;
    logic [2:0]          r_status;
    logic [4:0]          r_fired;
    t_desc               r_odesc;
    logic                r_ovalid;
    logic                r_done;

    // Memory ports.
    logic                q_we;
    logic [QIDX_W-1:0]   q_waddr, q_raddr;
    t_desc               q_wdata, q_rdata;
    logic                t_we;
    logic [TIDX_W-1:0]   t_waddr, t_raddr;
    logic [DELAY_BITS+63:0] t_wdata, t_rdata;

    dtqs_ram #(.WIDTH(64), .DEPTH(QUEUE_SLOTS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );
    dtqs_ram #(.WIDTH(DELAY_BITS + 64), .DEPTH(TIMER_SLOTS)) u_timers (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    t_desc               w_desc;
    t_desc               w_tdesc;
    logic [DELAY_BITS-1:0] w_trem;
    logic [QIDX_W-1:0]   w_tail_nx, w_head_pv;
    logic                w_qfull;
    logic                w_tfull;
    logic [DELAY_BITS-1:0] w_delay, w_retry;

    always_comb begin
        w_desc  = '{handle: r_req.task_handle, count: r_req.arg_count,
                    ref_arg: r_req.arg_ref};
        w_tdesc = t_desc'(t_rdata[DELAY_BITS +: 64]);
        w_trem  = t_rdata[DELAY_BITS-1:0];
        w_tail_nx = (r_tail == QIDX_W'(QUEUE_SLOTS - 1)) ? '0 : r_tail + 1'b1;
        w_head_pv = (r_head == '0) ? QIDX_W'(QUEUE_SLOTS - 1) : r_head - 1'b1;
        w_qfull = (w_tail_nx == r_head);
        w_tfull = (r_used >= TCNT_W'(TIMER_SLOTS));
        w_delay = DELAY_BITS'(r_req.delay_ticks);
        w_retry = DELAY_BITS'(r_retry);
    end

    // Memory port drive from the sequencer.
    always_comb begin
        q_we = 1'b0; q_waddr = r_tail; q_wdata = w_desc; q_raddr = r_head;
        t_we = 1'b0; t_waddr = r_idx[TIDX_W-1:0];
        t_wdata = {w_desc, w_delay};
        t_raddr = r_idx[TIDX_W-1:0];
        case (r_state)
            S_DECODE: begin
                case (r_req.req_type)
                    REQ_PUSH_BACK: q_we = !w_qfull;
                    REQ_PUSH_FRNT: begin
                        if (w_head_pv != r_tail) begin
                            q_we = 1'b1; q_waddr = w_head_pv;
                        end else if (w_retry != '0 && !w_tfull) begin
                            t_we = 1'b1; t_waddr = r_used[TIDX_W-1:0];
                            t_wdata = {w_desc, w_retry};
                        end else begin
                            q_we = (w_retry == '0) && !w_qfull;
                        end
                    end
                    REQ_START: begin
                        if (w_delay == '0) begin
                            q_we = !w_qfull;
                        end else if (!w_tfull) begin
                            t_we = 1'b1; t_waddr = r_used[TIDX_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            S_TACT: begin
                if (r_req.req_type == REQ_TICK) begin
                    if (w_trem > DELAY_BITS'(1)) begin
                        t_we = 1'b1; t_wdata = {w_tdesc, w_trem - 1'b1};
                    end else begin
                        q_we = !w_qfull; q_wdata = w_tdesc;
                    end
                end else if (r_req.req_type == REQ_UPDATE && w_tdesc == w_desc) begin
                    t_we = 1'b1; t_wdata = {w_tdesc, w_delay};
                end
            end
            // The last entry's address is held through the read and wait states so that
            // the registered read data still holds it when it is moved.
            S_LRD, S_LWAIT: t_raddr = TIDX_W'(r_used);
            S_LMOVE: begin
                t_we = 1'b1; t_wdata = t_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_used  <= '0;
            r_ticks <= '0;
            r_retry <= 32'd1;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_retry <= pwdata;
            end
            case (r_state)
                S_IDLE: begin
                    // No request is taken during the result beat, while busy is high.
                    if (start && !r_done) begin
                        r_req    <= i_req;
                        r_state  <= S_DECODE;
                        r_status <= ST_OK;
                        r_fired  <= '0;
                        r_ovalid <= 1'b0;
                        r_odesc  <= '0;
                        r_idx    <= '0;
                    end
                end
                S_DECODE: begin
                    r_state <= S_DONE;
                    case (r_req.req_type)
                        REQ_TICK: begin
                            r_ticks <= r_ticks + 1'b1;
                            r_state <= S_TRD;
                        end
                        REQ_PUSH_BACK: begin
                            if (w_qfull) r_status <= ST_QOVF;
                            else r_tail <= w_tail_nx;
                        end
                        REQ_PUSH_FRNT: begin
                            if (w_head_pv != r_tail) begin
                                r_head <= w_head_pv;
                            end else if (w_retry != '0) begin
                                if (w_tfull) r_status <= ST_TFULL;
                                else r_used <= r_used + 1'b1;
                            end else begin
                                if (w_qfull) r_status <= ST_QOVF;
                                else r_tail <= w_tail_nx;
                            end
                        end
                        REQ_START: begin
                            if (w_delay == '0) begin
                                if (w_qfull) r_status <= ST_QOVF;
                                else r_tail <= w_tail_nx;
                            end else if (w_tfull) begin
                                r_status <= ST_TFULL;
                            end else begin
                                r_used <= r_used + 1'b1;
                            end
                        end
                        REQ_UPDATE, REQ_DELETE: r_state <= S_TRD;
                        REQ_DISPATCH: begin
                            if (r_head == r_tail) r_status <= ST_EMPTY;
                            else r_state <= S_QRD;
                        end
                        REQ_CLR_TASKS: begin
                            r_head <= '0; r_tail <= '0;
                        end
                        REQ_CLR_TMRS: r_used <= '0;
                        default: ;
                    endcase
                end
                S_QRD: r_state <= S_QOUT;
                S_QOUT: begin
                    r_odesc  <= q_rdata;
                    r_ovalid <= 1'b1;
                    r_head   <= (r_head == QIDX_W'(QUEUE_SLOTS - 1)) ? '0 : r_head + 1'b1;
                    r_state  <= S_DONE;
                end
                S_TRD: begin
                    if (r_idx < r_used) begin
                        r_state <= S_TWAIT;
                    end else begin
                        if (r_req.req_type != REQ_TICK) r_status <= ST_NOTFOUND;
                        r_state <= S_DONE;
                    end
                end
                S_TWAIT: r_state <= S_TACT;
                S_TACT: begin
                    if (r_req.req_type == REQ_TICK) begin
                        if (w_trem > DELAY_BITS'(1)) begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_TRD;
                        end else begin
                            if (w_qfull) begin
                                r_status <= ST_QOVF;
                            end else begin
                                r_tail  <= w_tail_nx;
                                r_fired <= r_fired + 1'b1;
                            end
                            r_used  <= r_used - 1'b1;
                            r_state <= S_LRD;
                        end
                    end else if (w_tdesc == w_desc) begin
                        if (r_req.req_type == REQ_DELETE) begin
                            r_used  <= r_used - 1'b1;
                            r_state <= S_LRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_LRD: r_state <= S_LWAIT;
                S_LWAIT: r_state <= S_LMOVE;
                S_LMOVE: begin
                    // The moved-in entry is examined in turn on a tick.
                    r_state <= (r_req.req_type == REQ_TICK) ? S_TRD : S_DONE;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [QIDX_W:0] w_occ;
    always_comb begin
        w_occ = (r_tail >= r_head) ? {1'b0, r_tail} - {1'b0, r_head}
                : (QIDX_W+1)'(QUEUE_SLOTS) - ({1'b0, r_head} - {1'b0, r_tail});
        o_rsp.status           = r_status;
        o_rsp.task_valid       = r_ovalid;
        o_rsp.out_task_handle  = r_odesc.handle;
        o_rsp.out_arg_count    = r_odesc.count;
        o_rsp.out_arg_ref      = r_odesc.ref_arg;
        o_rsp.fired_count      = r_fired;
        o_rsp.free_task_slots  = 5'(QUEUE_SLOTS) - 5'(w_occ);
        o_rsp.free_timer_slots = 5'(TIMER_SLOTS) - 5'(r_used);
        o_rsp.tick_count       = r_ticks;
    end

    assign o_done = r_done;
    assign busy   = (r_state != S_IDLE) || r_done;
    assign prdata = (paddr == 2'd0) ? r_retry : 32'd0;
    assign pready = 1'b1;
endmodule

>>> rtl/dtqs_checker.sv
// Port-level checker for the delayed task queue scheduler; uses dtqs_pkg.
// Bound to the top level below.
module dtqs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input dtqs_pkg::t_rsp o_rsp,
    input logic           pready
);
    import dtqs_pkg::*;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat while not busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result beat repeated");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted request not busy");
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.task_valid |-> o_rsp.status == ST_OK)
        else $error("dispatched task with error status");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind delayed_task_queue_scheduler dtqs_checker u_dtqs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_rsp(o_rsp), .pready(pready)
);

>>> dv/delayed_task_queue_scheduler_test.sv
// Self-checking testbench for the delayed task queue scheduler: a directed table followed
// by biased random requests, checked against a predictor or, for some rows, typed results.
// Depends on dtqs_pkg and the delayed_task_queue_scheduler RTL only.
`timescale 1ns / 100ps

module delayed_task_queue_scheduler_test;
    import dtqs_pkg::*;

    // The only register, busy_retry_delay, sits at byte address 0.
    localparam logic [1:0] ADDR_RETRY_DELAY = 2'd0;
    // Longest request is a tick that removes every timer.
    localparam int SETTLE_CYCLES = 6 * TIMER_SLOTS + 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    delayed_task_queue_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: ring queue, timer table and the retry register.
    // The ring keeps one slot free, so 4-bit head/tail arithmetic wraps
    // exactly as the block's pointers do.
    // ------------------------------------------------------------------
    t_desc       ready_ring [QUEUE_SLOTS];
    logic [3:0]  ring_head = '0;
    logic [3:0]  ring_tail = '0;
    t_desc       timer_desc [TIMER_SLOTS];
    logic [31:0] timer_left [TIMER_SLOTS];
    int          timers_in_use = 0;
    logic [31:0] ticks_seen = '0;
    logic [31:0] retry_delay = 32'd1;

    t_rsp        expected_rsps[$];
    int          errors = 0;
    bit          quiet_tail = 1'b0;
    t_desc       desc_pool [6];

    function automatic logic [2:0] ring_push(t_desc d);
        if (ring_tail + 4'd1 == ring_head) return ST_QOVF;
        ready_ring[ring_tail] = d;
        ring_tail = ring_tail + 4'd1;
        return ST_OK;
    endfunction

    function automatic logic [2:0] arm_timer(t_desc d, logic [31:0] delay);
        if (delay == 0) return ring_push(d);
        if (timers_in_use >= TIMER_SLOTS) return ST_TFULL;
        timer_desc[timers_in_use] = d;
        timer_left[timers_in_use] = delay;
        timers_in_use++;
        return ST_OK;
    endfunction

    // Removal moves the last entry into the hole, as the table is unordered.
    function automatic void drop_timer(int idx);
        timers_in_use--;
        timer_desc[idx] = timer_desc[timers_in_use];
        timer_left[idx] = timer_left[timers_in_use];
    endfunction

    function automatic int find_timer(t_desc d);
        for (int k = 0; k < timers_in_use; k++)
            if (timer_desc[k] == d) return k;
        return -1;
    endfunction

    function automatic t_rsp schedule_step(t_req r);
        t_rsp  o;
        t_desc d;
        int    idx;
        logic [3:0] prev;
        o = '0;
        d = '{r.task_handle, r.arg_count, r.arg_ref};
        o.status = ST_OK;
        case (r.req_type)
            REQ_TICK: begin
                ticks_seen = ticks_seen + 1;
                idx = 0;
                // An expired slot is refilled by the last entry, which gets
                // examined at the same index before moving on.
                while (idx < timers_in_use) begin
                    if (timer_left[idx] > 1) begin
                        timer_left[idx] = timer_left[idx] - 1;
                        idx++;
                    end else begin
                        if (ring_push(timer_desc[idx]) == ST_OK)
                            o.fired_count = o.fired_count + 5'd1;
                        else
                            o.status = ST_QOVF;
                        drop_timer(idx);
                    end
                end
            end
            REQ_PUSH_BACK: o.status = ring_push(d);
            REQ_PUSH_FRNT: begin
                prev = ring_head - 4'd1;
                if (prev != ring_tail) begin
                    ring_head = prev;
                    ready_ring[prev] = d;
                end else begin
                    // Full queue: retried via a timer unless the delay is zero or the table full.
                    o.status = arm_timer(d, retry_delay);
                end
            end
            REQ_START: o.status = arm_timer(d, r.delay_ticks);
            REQ_UPDATE: begin
                idx = find_timer(d);
                if (idx >= 0) timer_left[idx] = r.delay_ticks;
                else o.status = ST_NOTFOUND;
            end
            REQ_DELETE: begin
                idx = find_timer(d);
                if (idx >= 0) drop_timer(idx);
                else o.status = ST_NOTFOUND;
            end
            REQ_DISPATCH: begin
                if (ring_head != ring_tail) begin
                    o.task_valid = 1'b1;
                    o.out_task_handle = ready_ring[ring_head].handle;
                    o.out_arg_count = ready_ring[ring_head].count;
                    o.out_arg_ref = ready_ring[ring_head].ref_arg;
                    ring_head = ring_head + 4'd1;
                end else begin
                    o.status = ST_EMPTY;
                end
            end
            REQ_CLR_TASKS: begin
                ring_head = '0;
                ring_tail = '0;
            end
            REQ_CLR_TMRS: timers_in_use = 0;
            default: ;
        endcase
        o.free_task_slots = 5'(QUEUE_SLOTS) - {1'b0, ring_tail - ring_head};
        o.free_timer_slots = 5'(TIMER_SLOTS - timers_in_use);
        o.tick_count = ticks_seen;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. The strobe lasts one cycle and cannot be stalled,
    // so every edge with o_done high carries one result beat.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        errors++;
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) report_mismatch(what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result beat", '0, o_rsp.status);
            end else begin
                want = expected_rsps.pop_front();
                check_field("status", want.status, o_rsp.status);
                check_field("task_valid", want.task_valid, o_rsp.task_valid);
                check_field("out_task_handle", want.out_task_handle, o_rsp.out_task_handle);
                check_field("out_arg_count", want.out_arg_count, o_rsp.out_arg_count);
                check_field("out_arg_ref", want.out_arg_ref, o_rsp.out_arg_ref);
                check_field("fired_count", want.fired_count, o_rsp.fired_count);
                check_field("free_task_slots", want.free_task_slots, o_rsp.free_task_slots);
                check_field("free_timer_slots", want.free_timer_slots,
                            o_rsp.free_timer_slots);
                check_field("tick_count", want.tick_count, o_rsp.tick_count);
            end
        end
    end

    // Watchdog: any accepted request or result beat counts as progress.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("delayed_task_queue_scheduler: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Each task is entered right after a rising edge. start is
    // left high after an accepted beat so that back-to-back requests never
    // lower and raise it within one time step.
    // ------------------------------------------------------------------
    task automatic issue_request(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp predicted;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predicted = schedule_step(r);
        expected_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic maybe_idle();
        if (!quiet_tail && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
    endtask

    // Wait for every outstanding result, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_retry_delay(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_RETRY_DELAY;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        retry_delay = value;
        @(posedge i_clk);
    endtask

    function automatic t_req mk_req(logic [3:0] kind, t_desc d, logic [31:0] delay);
        t_req r;
        r.req_type = kind;
        r.task_handle = d.handle;
        r.arg_count = d.count;
        r.arg_ref = d.ref_arg;
        r.delay_ticks = delay;
        return r;
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(9))
            0: return 32'd0;
            7: return 32'hFFFF_FFFF;
            8: return $urandom;
            9: return 32'd1;
            default: return $urandom_range(4, 1);
        endcase
    endfunction

    // Mostly descriptors from a small pool so that update and delete find
    // their timers; now and then a fully random one.
    function automatic t_desc pick_desc();
        if ($urandom_range(9) == 0)
            return '{16'($urandom), 16'($urandom), 32'($urandom)};
        return desc_pool[$urandom_range(5)];
    endfunction

    // fill_bias leans toward pushes and timer starts so the queue and
    // table reach full; otherwise dispatch and ticks drain them.
    function automatic t_req random_request(bit fill_bias);
        int roll;
        logic [3:0] kind;
        roll = $urandom_range(99);
        if (roll < 3)       kind = 4'($urandom_range(15, 9));
        else if (roll < 5)  kind = REQ_CLR_TASKS;
        else if (roll < 7)  kind = REQ_CLR_TMRS;
        else if (roll < 17) kind = REQ_UPDATE;
        else if (roll < 25) kind = REQ_DELETE;
        else if (roll < (fill_bias ? 45 : 40)) kind = REQ_START;
        else if (roll < (fill_bias ? 65 : 48)) kind = REQ_PUSH_BACK;
        else if (roll < (fill_bias ? 75 : 53)) kind = REQ_PUSH_FRNT;
        else if (roll < (fill_bias ? 88 : 75)) kind = REQ_TICK;
        else                kind = REQ_DISPATCH;
        return mk_req(kind, pick_desc(), pick_delay());
    endfunction

    // ------------------------------------------------------------------
    // Directed table: rows with a typed result are only those whose answer
    // is plain from reset state; the rest go through the predictor.
    // ------------------------------------------------------------------
    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp rsp;
    } t_row;

    t_row plan[$];

    task automatic add_row(t_req r, bit typed = 1'b0, t_rsp rsp = '0);
        t_row row;
        row.rq = r;
        row.typed = typed;
        row.rsp = rsp;
        plan.push_back(row);
    endtask

    initial begin
        t_desc ones, zeros, mid;
        ones = '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
        zeros = '0;
        mid = '{16'h5A5A, 16'h00A5, 32'h8000_0001};
        foreach (desc_pool[k])
            desc_pool[k] = '{16'($urandom), 16'($urandom), 32'($urandom)};

        // Empty dispatch, idle tick, lookups that find nothing, then a back push and its dispatch.
        add_row(mk_req(REQ_DISPATCH, zeros, 0), 1,
                '{ST_EMPTY, 1'b0, 16'd0, 16'd0, 32'd0, 5'd0, 5'd16, 5'd16, 32'd0});
        add_row(mk_req(REQ_TICK, zeros, 0), 1,
                '{ST_OK, 1'b0, 16'd0, 16'd0, 32'd0, 5'd0, 5'd16, 5'd16, 32'd1});
        add_row(mk_req(REQ_DELETE, ones, 0), 1,
                '{ST_NOTFOUND, 1'b0, 16'd0, 16'd0, 32'd0, 5'd0, 5'd16, 5'd16, 32'd1});
        add_row(mk_req(REQ_UPDATE, ones, 32'hFFFF_FFFF), 1,
                '{ST_NOTFOUND, 1'b0, 16'd0, 16'd0, 32'd0, 5'd0, 5'd16, 5'd16, 32'd1});
        add_row(mk_req(REQ_PUSH_BACK, ones, 0), 1,
                '{ST_OK, 1'b0, 16'd0, 16'd0, 32'd0, 5'd0, 5'd15, 5'd16, 32'd1});
        add_row(mk_req(REQ_DISPATCH, zeros, 0), 1,
                '{ST_OK, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 5'd16, 5'd16,
                  32'd1});
        // Front push, zero-delay start, timers at both delay extremes.
        add_row(mk_req(REQ_PUSH_FRNT, zeros, 0));
        add_row(mk_req(REQ_START, mid, 32'd0));
        add_row(mk_req(REQ_START, ones, 32'hFFFF_FFFF));
        add_row(mk_req(REQ_START, zeros, 32'd1));
        add_row(mk_req(REQ_START, mid, 32'd3));
        // Update to zero makes the entry fire on the next tick.
        add_row(mk_req(REQ_UPDATE, mid, 32'd0));
        add_row(mk_req(REQ_TICK, zeros, 0));
        add_row(mk_req(REQ_DELETE, ones, 0));
        add_row(mk_req(4'd9, ones, 32'hFFFF_FFFF));
        add_row(mk_req(4'd15, ones, 32'hFFFF_FFFF));
        add_row(mk_req(REQ_DISPATCH, zeros, 0));
        add_row(mk_req(REQ_DISPATCH, zeros, 0));
        add_row(mk_req(REQ_PUSH_BACK, mid, 0));
        add_row(mk_req(REQ_CLR_TASKS, zeros, 0));
        add_row(mk_req(REQ_START, ones, 32'd2));
        add_row(mk_req(REQ_CLR_TMRS, zeros, 0));
        add_row(mk_req(REQ_DISPATCH, zeros, 0));
        add_row(mk_req(REQ_TICK, ones, 32'hFFFF_FFFF));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            issue_request(plan[k].rq, plan[k].typed, plan[k].rsp);
            maybe_idle();
        end

        // Random phases, each under its own retry delay; the drain before
        // every register write also makes the sender wait for all results.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: write_retry_delay(32'd1);
                1: write_retry_delay(32'hFFFF_FFFF);
                2: write_retry_delay(32'd2);
                default: write_retry_delay($urandom_range(6, 1));
            endcase
            quiet_tail = (ph >= RANDOM_PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_request(random_request((n / 25) % 2 == 0), 1'b0, '0);
                maybe_idle();
            end
        end

        drain();
        if (errors == 0)
            $display("delayed_task_queue_scheduler: match");
        else
            $display("delayed_task_queue_scheduler: mismatch");
        $finish;
    end
endmodule

>>> files.f
rtl/dtqs_pkg.sv
rtl/dtqs_ram.sv
rtl/delayed_task_queue_scheduler.sv
rtl/dtqs_checker.sv
dv/delayed_task_queue_scheduler_test.sv
